@@ rtl/core/dirrle_pkg.sv @@
// ---------------------------------------------------------------------------
// dirrle_pkg: shared types and constants for the record RLE decoder
// Parse phases, result kinds, register indexes and the structs passed
// between the parser and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dirrle_pkg;

   // byte that opens every record
   localparam logic [7:0] START_MARK = 8'hff;

   // configuration register indexes
   localparam logic [1:0] CSR_FIXED_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FIXED_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GRAY_MODE    = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_GRAY   = 2'd2;

   // record parse phase
   typedef enum logic [2:0] {
      PH_MARK   = 3'd0,
      PH_LABEL  = 3'd1,
      PH_WIDTH  = 3'd2,
      PH_HEIGHT = 3'd3,
      PH_CNT_LO = 3'd4,
      PH_CNT_HI = 3'd5,
      PH_PIX    = 3'd6
   } phase_type;

   // configuration seen by the parser
   typedef struct packed {
      logic [7:0] fixed_width;
      logic [7:0] fixed_height;
      logic       gray_mode;
   } cfg_type;

   // one result word
   typedef struct packed {
      logic [1:0] item_kind;
      logic [7:0] sample_label;
      logic [7:0] image_width;
      logic [7:0] image_height;
      logic [7:0] row_index;
      logic [7:0] column_index;
      logic [7:0] run_length;
      logic [7:0] pixel_value;
      logic       record_end;
      logic       marker_bad;
      logic       run_overflow;
   } result_type;

endpackage

@@ rtl/core/dirrle_parse.sv @@
// ---------------------------------------------------------------------------
// dirrle_parse: record parser and row/column tracker
// Holds the record state, steps it on each accepted byte and forms the
// result word that byte causes, if any.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dirrle_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             data_byte,
   input  dirrle_pkg::cfg_type    cfg,
   output logic                   res_valid,
   output dirrle_pkg::result_type res
);

   dirrle_pkg::phase_type phase_ff, phase_in;
   logic [7:0] width_ff,  width_in;
   logic [7:0] height_ff, height_in;
   logic [7:0] label_ff,  label_in;
   logic [7:0] row_ff,    row_in;
   logic [7:0] col_ff,    col_in;
   logic       fg_ff,     fg_in;
   logic       bad_ff,    bad_in;

   logic       fixed_dims;
   logic       rec_empty;
   logic [7:0] cols_left;
   logic [7:0] run_len;
   logic       run_ovf;
   logic [7:0] pix_step;
   logic [7:0] next_col;
   logic [7:0] next_row;
   logic       zero_run;
   logic       row_full;
   logic       last_row;

   // shared datapath: run clamp and row/column advance
   always_comb begin
      fixed_dims = (cfg.fixed_width != 8'd0) && (cfg.fixed_height != 8'd0);
      rec_empty  = (width_ff == 8'd0) || (height_ff == 8'd0);
      cols_left  = width_ff - col_ff;
      run_ovf    = data_byte > cols_left;
      run_len    = run_ovf ? cols_left : data_byte;
      pix_step   = cfg.gray_mode ? 8'd1 : run_len;
      next_col   = col_ff + pix_step;
      next_row   = row_ff + 8'd1;
      zero_run   = !cfg.gray_mode && (data_byte == 8'd0);
      row_full   = !zero_run && (next_col >= width_ff);
      last_row   = row_full && (next_row >= height_ff);
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         dirrle_pkg::PH_LABEL:  phase_in = fixed_dims ? dirrle_pkg::PH_CNT_LO
                                                      : dirrle_pkg::PH_WIDTH;
         dirrle_pkg::PH_WIDTH:  phase_in = dirrle_pkg::PH_HEIGHT;
         dirrle_pkg::PH_HEIGHT: phase_in = dirrle_pkg::PH_CNT_LO;
         dirrle_pkg::PH_CNT_LO: phase_in = dirrle_pkg::PH_CNT_HI;
         dirrle_pkg::PH_CNT_HI: phase_in = rec_empty ? dirrle_pkg::PH_MARK
                                                     : dirrle_pkg::PH_PIX;
         dirrle_pkg::PH_PIX:    phase_in = last_row ? dirrle_pkg::PH_MARK
                                                    : dirrle_pkg::PH_PIX;
         default:               phase_in = dirrle_pkg::PH_LABEL;
      endcase
   end

   // record state updates and result word
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      label_in  = label_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      fg_in     = fg_ff;
      bad_in    = bad_ff;
      res_valid = 1'b0;

      res.item_kind    = dirrle_pkg::KIND_HEADER;
      res.sample_label = label_ff;
      res.image_width  = width_ff;
      res.image_height = height_ff;
      res.row_index    = 8'd0;
      res.column_index = 8'd0;
      res.run_length   = 8'd0;
      res.pixel_value  = 8'd0;
      res.record_end   = 1'b0;
      res.marker_bad   = 1'b0;
      res.run_overflow = 1'b0;

      unique case (phase_ff)
         dirrle_pkg::PH_LABEL: begin
            label_in = data_byte;
            if (fixed_dims) begin
               width_in  = cfg.fixed_width;
               height_in = cfg.fixed_height;
            end
         end
         dirrle_pkg::PH_WIDTH:  width_in  = data_byte;
         dirrle_pkg::PH_HEIGHT: height_in = data_byte;
         dirrle_pkg::PH_CNT_LO: ;
         dirrle_pkg::PH_CNT_HI: begin
            row_in         = 8'd0;
            col_in         = 8'd0;
            fg_in          = 1'b0;
            res_valid      = 1'b1;
            res.record_end = rec_empty;
            res.marker_bad = bad_ff;
         end
         dirrle_pkg::PH_PIX: begin
            // colour flips on every run byte, zero runs included
            fg_in           = !fg_ff;
            res_valid       = !zero_run;
            res.row_index    = row_ff;
            res.column_index = col_ff;
            res.record_end   = last_row;
            if (cfg.gray_mode) begin
               fg_in            = fg_ff;
               res.item_kind    = dirrle_pkg::KIND_GRAY;
               res.run_length   = 8'd1;
               res.pixel_value  = data_byte;
            end else begin
               res.item_kind    = dirrle_pkg::KIND_RUN;
               res.run_length   = run_len;
               res.pixel_value  = {7'd0, fg_ff};
               res.run_overflow = run_ovf;
            end
            if (!zero_run) begin
               col_in = next_col;
            end
            // row complete: next row starts at column 0 with background
            if (row_full) begin
               col_in = 8'd0;
               fg_in  = 1'b0;
               row_in = next_row;
            end
         end
         default: bad_in = (data_byte != dirrle_pkg::START_MARK);
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dirrle_pkg::PH_MARK;
         width_ff  <= 8'd0;
         height_ff <= 8'd0;
         label_ff  <= 8'd0;
         row_ff    <= 8'd0;
         col_ff    <= 8'd0;
         fg_ff     <= 1'b0;
         bad_ff    <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         label_ff  <= label_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         fg_ff     <= fg_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

@@ rtl/core/digit_image_record_rle_decoder_unit.sv @@
// ---------------------------------------------------------------------------
// digit_image_record_rle_decoder_unit: sample record stream decoder
// Parses record bytes (marker, label, dims, count, pixels) and emits a
// header word per record, one word per nonzero binary run or per gray pixel.
// ---------------------------------------------------------------------------
//   channel | ports                    | direction | word
//   req     | req_valid/req_stall      | in        | one record byte
//   rsp     | rsp_valid/rsp_stall      | out       | header, run or pixel
//   csr     | csr_write/index/wdata    | in        | fixed dims, gray mode
//
// One byte per cycle while req_stall is low; a byte's result appears in the
// output register on the cycle after it is taken. Parser state, config and
// output registers are the only storage. req_stall is raised only while the
// output register holds a word that rsp_stall is holding back. Sync reset
// returns the parser to expecting a start marker and clears all but the output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module digit_image_record_rle_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   // record bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   // results
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_item_kind,
   output logic [7:0] rsp_sample_label,
   output logic [7:0] rsp_image_width,
   output logic [7:0] rsp_image_height,
   output logic [7:0] rsp_row_index,
   output logic [7:0] rsp_column_index,
   output logic [7:0] rsp_run_length,
   output logic [7:0] rsp_pixel_value,
   output logic       rsp_record_end,
   output logic       rsp_marker_bad,
   output logic       rsp_run_overflow,
   // configuration
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   dirrle_pkg::cfg_type    cfg_ff;
   dirrle_pkg::result_type res;
   dirrle_pkg::result_type rsp_ff;
   logic                   res_valid;
   logic                   rsp_valid_ff;
   logic                   take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            dirrle_pkg::CSR_FIXED_WIDTH:  cfg_ff.fixed_width  <= csr_wdata;
            dirrle_pkg::CSR_FIXED_HEIGHT: cfg_ff.fixed_height <= csr_wdata;
            dirrle_pkg::CSR_GRAY_MODE:    cfg_ff.gray_mode    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   dirrle_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item_kind    = rsp_ff.item_kind;
   assign rsp_sample_label = rsp_ff.sample_label;
   assign rsp_image_width  = rsp_ff.image_width;
   assign rsp_image_height = rsp_ff.image_height;
   assign rsp_row_index    = rsp_ff.row_index;
   assign rsp_column_index = rsp_ff.column_index;
   assign rsp_run_length   = rsp_ff.run_length;
   assign rsp_pixel_value  = rsp_ff.pixel_value;
   assign rsp_record_end   = rsp_ff.record_end;
   assign rsp_marker_bad   = rsp_ff.marker_bad;
   assign rsp_run_overflow = rsp_ff.run_overflow;

endmodule
